@@ rtl/darx_pkg.sv @@
// Shared types and constants for the DNS answer record extractor.
package darx_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
  localparam logic [1:0] STATUS_NONE      = 2'd2;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       end_of_packet;
  } byte_t;

  typedef struct packed {
    logic [16:0] record_index;
    logic [15:0] name_offset;
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [31:0] time_to_live;
    logic [15:0] rdata_length;
    logic [15:0] rdata_offset;
    logic [31:0] ipv4_address;
    logic [1:0]  status;
    logic        final_res;
  } rec_t;

endpackage

@@ rtl/darx_if.sv @@
// Stream interfaces for message bytes, extracted records and configuration writes.
interface darx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

interface darx_rec_if;
  logic        valid;
  logic        ready;
  logic [16:0] record_index;
  logic [15:0] name_offset;
  logic [15:0] record_type;
  logic [15:0] record_class;
  logic [31:0] time_to_live;
  logic [15:0] rdata_length;
  logic [15:0] rdata_offset;
  logic [31:0] ipv4_address;
  logic [1:0]  status;
  logic        final_res;

  modport source (output valid, output record_index, output name_offset, output record_type,
                  output record_class, output time_to_live, output rdata_length,
                  output rdata_offset, output ipv4_address, output status,
                  output final_res, input ready);
  modport sink   (input valid, input record_index, input name_offset, input record_type,
                  input record_class, input time_to_live, input rdata_length,
                  input rdata_offset, input ipv4_address, input status,
                  input final_res, output ready);
  modport monitor (input valid, input ready, input record_index, input name_offset,
                   input record_type, input record_class, input time_to_live,
                   input rdata_length, input rdata_offset, input ipv4_address,
                   input status, input final_res);
endinterface

interface darx_cfg_if;
  logic valid;
  logic ready;
  logic address_types_only;

  modport source (output valid, output address_types_only, input ready);
  modport sink   (input valid, input address_types_only, output ready);
endinterface

@@ rtl/dns_answer_record_extractor_unit.sv @@
// An accepted byte is registered in the input stage, and its result in the result register.
// Throughput: one byte per cycle; the record channel stalls bytes only when
// a byte has a result and the result register is still full.
// Reset clears the parse state and the valid bits of both stage registers; the type filter
// register comes out of reset set to address types only.
module dns_answer_record_extractor_unit import darx_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  darx_byte_if.sink  byte_i,
  darx_cfg_if.sink   cfg_i,
  darx_rec_if.source rec_o
);

  logic  addr_only_q;
  logic  in_valid;
  byte_t in_data;
  logic  has_result;
  rec_t  result;
  logic  out_free;
  logic  advance;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_only_q <= 1'b1;
    end else if (cfg_i.valid) begin
      addr_only_q <= cfg_i.address_types_only;
    end
  end

  // A byte without a result moves on even while the result register is full.
  assign advance = in_valid && (!has_result || out_free);

  darx_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .data_o    (in_data)
  );

  darx_parser #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .commit_i     (advance),
    .data_i       (in_data),
    .addr_only_i  (addr_only_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  darx_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && has_result),
    .data_i (result),
    .free_o (out_free),
    .rec_o  (rec_o)
  );

endmodule

@@ rtl/darx_in_stage.sv @@
// Input register that holds one accepted message byte for the parser.
module darx_in_stage import darx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  darx_byte_if.sink         byte_i,
  input  logic              advance_i,
  output logic              valid_o,
  output byte_t             data_o
);

  logic  valid_q, valid_d;
  byte_t data_q;

  assign byte_i.ready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (byte_i.ready) begin
      valid_d = byte_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      data_q.packet_byte   <= byte_i.packet_byte;
      data_q.end_of_packet <= byte_i.end_of_packet;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/darx_parser.sv @@
// Message parse state and the per-byte next-state and result logic.
module darx_parser import darx_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = 65535
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  commit_i,
  input  byte_t data_i,
  input  logic  addr_only_i,
  output logic  has_result_o,
  output rec_t  result_o
);

  localparam logic [3:0] PH_HDR    = 4'd0;
  localparam logic [3:0] PH_QLEN   = 4'd1;
  localparam logic [3:0] PH_QLABEL = 4'd2;
  localparam logic [3:0] PH_QPTR   = 4'd3;
  localparam logic [3:0] PH_QFIX   = 4'd4;
  localparam logic [3:0] PH_RSTART = 4'd5;
  localparam logic [3:0] PH_RLEN   = 4'd6;
  localparam logic [3:0] PH_RLABEL = 4'd7;
  localparam logic [3:0] PH_RPTR   = 4'd8;
  localparam logic [3:0] PH_RFIX   = 4'd9;
  localparam logic [3:0] PH_RDATA  = 4'd10;

  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] TYPE_IPV6  = 16'd28;
  localparam logic [15:0] TYPE_ALIAS = 16'd5;
  localparam logic [15:0] POS_LIMIT  = 16'(MAX_MESSAGE_BYTES);
  localparam logic [15:0] POS_MAX    = 16'hFFFF;

  logic [15:0] pos_q, pos_d;
  logic [3:0]  phase_q, phase_d;
  logic [16:0] remaining_q, remaining_d;
  logic [16:0] seen_q, seen_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] left_q, left_d;
  logic [15:0] rtype_q, rtype_d;
  logic [15:0] rclass_q, rclass_d;
  logic [31:0] ttl_q, ttl_d;
  logic [15:0] rlen_q, rlen_d;
  logic [31:0] ip_q, ip_d;
  logic [15:0] name_off_q, name_off_d;
  logic [15:0] rdata_off_q, rdata_off_d;
  logic        stopped_q, stopped_d;

  logic [7:0]  b;
  logic [31:0] fshift;
  logic [15:0] hdr_word;
  logic [15:0] data_idx;
  logic        rec_name;
  logic        complete;
  logic        report;
  logic        truncated;

  assign b        = data_i.packet_byte;
  assign fshift   = {shift_q[23:0], b};
  assign hdr_word = {shift_q[7:0], b};
  assign data_idx = rlen_q - left_q;
  assign rec_name = (phase_q != PH_QLEN);

  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    remaining_d = remaining_q;
    seen_d      = seen_q;
    shift_d     = shift_q;
    left_d      = left_q;
    rtype_d     = rtype_q;
    rclass_d    = rclass_q;
    ttl_d       = ttl_q;
    rlen_d      = rlen_q;
    ip_d        = ip_q;
    name_off_d  = name_off_q;
    rdata_off_d = rdata_off_q;
    stopped_d   = stopped_q;
    complete    = 1'b0;

    if (!stopped_q && (pos_q < POS_LIMIT)) begin
      unique case (phase_q)
        PH_HDR: begin
          if (pos_q == 16'd6 || pos_q == 16'd7) begin
            remaining_d = {1'b0, remaining_q[7:0], b};
          end else if (pos_q == 16'd8 || pos_q == 16'd9) begin
            shift_d = {16'h0000, hdr_word};
          end
          if (pos_q == 16'd9) begin
            remaining_d = remaining_q + {1'b0, hdr_word};
            shift_d     = '0;
          end
          if (pos_q >= 16'd11) begin
            phase_d = PH_QLEN;
          end
        end
        PH_QLEN, PH_RSTART, PH_RLEN: begin
          if (phase_q == PH_RSTART) begin
            rtype_d     = '0;
            rclass_d    = '0;
            ttl_d       = '0;
            rlen_d      = '0;
            ip_d        = '0;
            rdata_off_d = '0;
            name_off_d  = pos_q;
          end
          // A zero byte ends the name, top bits 11 mark a compression pointer.
          if (b == 8'h00) begin
            phase_d = rec_name ? PH_RFIX : PH_QFIX;
            left_d  = rec_name ? 16'd10 : 16'd4;
            shift_d = '0;
          end else if (b[7:6] == 2'b11) begin
            phase_d = rec_name ? PH_RPTR : PH_QPTR;
          end else begin
            left_d  = {8'h00, b};
            phase_d = rec_name ? PH_RLABEL : PH_QLABEL;
          end
        end
        PH_QLABEL, PH_RLABEL: begin
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            phase_d = (phase_q == PH_QLABEL) ? PH_QLEN : PH_RLEN;
          end
        end
        PH_QPTR: begin
          phase_d = PH_QFIX;
          left_d  = 16'd4;
        end
        PH_QFIX: begin
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            if (remaining_q == '0) begin
              stopped_d = 1'b1;
            end else begin
              phase_d = PH_RSTART;
            end
          end
        end
        PH_RPTR: begin
          phase_d = PH_RFIX;
          left_d  = 16'd10;
          shift_d = '0;
        end
        PH_RFIX: begin
          left_d  = left_q - 16'd1;
          shift_d = fshift;
          if (left_d == 16'd8) begin
            rtype_d = fshift[15:0];
            shift_d = '0;
          end else if (left_d == 16'd6) begin
            rclass_d = fshift[15:0];
            shift_d  = '0;
          end else if (left_d == 16'd2) begin
            ttl_d   = fshift;
            shift_d = '0;
          end else if (left_d == 16'd0) begin
            rlen_d      = fshift[15:0];
            ip_d        = '0;
            rdata_off_d = pos_q + 16'd1;
            shift_d     = '0;
            if (fshift[15:0] == 16'd0) begin
              complete = 1'b1;
            end else begin
              left_d  = fshift[15:0];
              phase_d = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          if (rtype_q == TYPE_A && data_idx < 16'd4) begin
            ip_d = {ip_q[23:0], b};
          end
          left_d   = left_q - 16'd1;
          complete = (left_q == 16'd1);
        end
        default: begin
          stopped_d = 1'b1;
        end
      endcase
    end

    report = complete && (!addr_only_i || rtype_d == TYPE_A || rtype_d == TYPE_IPV6 ||
                          rtype_d == TYPE_ALIAS);

    if (complete) begin
      seen_d      = seen_q + 17'd1;
      remaining_d = remaining_q - 17'd1;
      if (remaining_q == 17'd1) begin
        stopped_d = 1'b1;
      end else begin
        phase_d = PH_RSTART;
      end
    end

    truncated = !stopped_d && (phase_d >= PH_RLEN) && (phase_d <= PH_RDATA);

    result_o.record_index = seen_q;
    result_o.name_offset  = name_off_d;
    result_o.record_type  = rtype_d;
    result_o.record_class = rclass_d;
    result_o.time_to_live = ttl_d;
    result_o.rdata_length = rlen_d;
    result_o.rdata_offset = rdata_off_d;
    result_o.ipv4_address = ip_d;
    result_o.status       = report ? STATUS_COMPLETE : STATUS_TRUNCATED;
    result_o.final_res    = data_i.end_of_packet;
    if (data_i.end_of_packet && !report && !truncated) begin
      result_o        = '0;
      result_o.status = STATUS_NONE;
      result_o.final_res = 1'b1;
    end
    has_result_o = report || data_i.end_of_packet;

    // The last byte of a message returns all parse state to its start.
    if (data_i.end_of_packet) begin
      pos_d       = '0;
      phase_d     = PH_HDR;
      remaining_d = '0;
      seen_d      = '0;
      shift_d     = '0;
      left_d      = '0;
      rtype_d     = '0;
      rclass_d    = '0;
      ttl_d       = '0;
      rlen_d      = '0;
      ip_d        = '0;
      name_off_d  = '0;
      rdata_off_d = '0;
      stopped_d   = 1'b0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PH_HDR;
      remaining_q <= '0;
      seen_q      <= '0;
      shift_q     <= '0;
      left_q      <= '0;
      rtype_q     <= '0;
      rclass_q    <= '0;
      ttl_q       <= '0;
      rlen_q      <= '0;
      ip_q        <= '0;
      name_off_q  <= '0;
      rdata_off_q <= '0;
      stopped_q   <= 1'b0;
    end else if (commit_i) begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      seen_q      <= seen_d;
      shift_q     <= shift_d;
      left_q      <= left_d;
      rtype_q     <= rtype_d;
      rclass_q    <= rclass_d;
      ttl_q       <= ttl_d;
      rlen_q      <= rlen_d;
      ip_q        <= ip_d;
      name_off_q  <= name_off_d;
      rdata_off_q <= rdata_off_d;
      stopped_q   <= stopped_d;
    end
  end

endmodule

@@ rtl/darx_out_stage.sv @@
// Result register that drives the record channel.
module darx_out_stage import darx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  rec_t        data_i,
  output logic        free_o,
  darx_rec_if.source  rec_o
);

  logic valid_q, valid_d;
  rec_t data_q;

  assign free_o = !valid_q || rec_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (rec_o.ready) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign rec_o.valid        = valid_q;
  assign rec_o.record_index = data_q.record_index;
  assign rec_o.name_offset  = data_q.name_offset;
  assign rec_o.record_type  = data_q.record_type;
  assign rec_o.record_class = data_q.record_class;
  assign rec_o.time_to_live = data_q.time_to_live;
  assign rec_o.rdata_length = data_q.rdata_length;
  assign rec_o.rdata_offset = data_q.rdata_offset;
  assign rec_o.ipv4_address = data_q.ipv4_address;
  assign rec_o.status       = data_q.status;
  assign rec_o.final_res    = data_q.final_res;

endmodule

@@ rtl/darx_checker.sv @@
// Port-level checks on the record channel, bound to the top level.
module darx_checker import darx_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  darx_rec_if.source rec_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_i.valid && !rec_i.ready |=> rec_i.valid)
    else $error("record valid dropped before transfer");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_i.valid && !rec_i.ready |=> $stable(rec_i.record_index) && $stable(rec_i.status)
      && $stable(rec_i.final_res))
    else $error("record payload changed while stalled");

  a_none_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_i.valid && rec_i.status == STATUS_NONE |-> rec_i.final_res &&
      rec_i.record_index == '0 && rec_i.name_offset == '0 && rec_i.record_type == '0 &&
      rec_i.time_to_live == '0 && rec_i.rdata_length == '0 && rec_i.ipv4_address == '0)
    else $error("empty result carries record fields");

  a_truncated_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_i.valid && rec_i.status == STATUS_TRUNCATED |-> rec_i.final_res)
    else $error("truncated record not marked final");

  a_ipv4_only_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_i.valid && rec_i.ipv4_address != '0 |-> rec_i.record_type == 16'd1)
    else $error("address reported for a non-A record");

endmodule

bind dns_answer_record_extractor_unit darx_checker u_darx_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .rec_i  (rec_o)
);
